>>> rtl/hufftbd_pkg.sv
package hufftbd_pkg;

	// table size and longest code
	localparam int TABLE_ENTRIES = 128;
	localparam int MAX_CODE_LEN  = 16;

	// fixed field widths
	localparam int SYM_W    = 7;
	localparam int IDX_W    = 7;
	localparam int FCODE_W  = 16;
	localparam int FLEN_W   = 5;
	localparam int BYTE_W   = 8;
	localparam int VBITS_W  = 4;
	localparam int CFG_W    = 8;

	// derived widths
	localparam int ADDR_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
	localparam int CODE_W  = (MAX_CODE_LEN > FCODE_W) ? MAX_CODE_LEN : FCODE_W;
	localparam int LCMP_W  = 6;
	localparam int BCNT_W  = $clog2(BYTE_W + 1);

	// item modes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// one stored table entry
	typedef struct packed {
		logic [SYM_W-1:0]   symbol;
		logic [FCODE_W-1:0] code;
		logic [FLEN_W-1:0]  length;
	} entry_t;

	// table write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            entry;
	} tbl_wr_t;

	// lookup request: read one entry and compare it with the running code
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  length;
	} lookup_t;

	// lookup response, registered, in the cycle after the request
	typedef struct packed {
		logic             valid;
		logic             match;
		logic [SYM_W-1:0] symbol;
	} lookup_rsp_t;

	// low-bit mask of a given length
	function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] ones;
		ones = '1;
		return ~(ones << len);
	endfunction

endpackage

>>> rtl/hufftbd_in_if.sv
interface hufftbd_in_if
	import hufftbd_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [IDX_W-1:0]     entry_index;
	logic [SYM_W-1:0]     entry_symbol;
	logic [FCODE_W-1:0]   entry_code;
	logic [FLEN_W-1:0]    entry_length;
	logic [BYTE_W-1:0]    data_byte;
	logic [VBITS_W-1:0]   valid_bits;

	modport source (
		output valid, mode, entry_index, entry_symbol, entry_code, entry_length,
		       data_byte, valid_bits,
		input  ready
	);
	modport sink (
		input  valid, mode, entry_index, entry_symbol, entry_code, entry_length,
		       data_byte, valid_bits,
		output ready
	);
endinterface

>>> rtl/hufftbd_out_if.sv
interface hufftbd_out_if
	import hufftbd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             error;
	logic             last;

	modport source (
		output valid, symbol, error, last,
		input  ready
	);
	modport sink (
		input  valid, symbol, error, last,
		output ready
	);
endinterface

>>> rtl/huffman_table_bit_decoder_core.sv
// Huffman table bit decoder.
// The in_ch channel carries load words (mode 0), each writing one code table
// entry, and decode words (mode 1), each bringing a byte whose leading
// valid_bits bits (saturated at 8) are read most significant first. Each bit
// is appended to a running code, then table entries 0 .. entries_in_use-1
// (at most 128) are read from the table memory one per cycle and checked
// by a single comparator; the lowest matching entry yields a symbol word on
// out_ch. A running code that reaches the maximum length unmatched yields an
// error word. The last word caused by a byte has last set; a partial code
// stays pending. cfg_we/cfg_wdata write entries_in_use; the user must do so
// only while the block is idle, the block itself does not enforce it.
// The table is scanned sequentially through the single memory read port; a
// hit at entry i ends that bit's scan. in_ch.ready is high only while idle,
// so a new byte or load word is taken only once the last one is done.
// Results leave through an output register; when out_ch stalls, the scan
// holds before passing on a second result. Reset clears the running code,
// entries_in_use and the output; table contents are undefined until loaded.
module huffman_table_bit_decoder_core
	import hufftbd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	hufftbd_in_if.sink         in_ch,
	hufftbd_out_if.source      out_ch
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_BIT    = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             error;
		logic             last;
	} result_t;

	state_t             state_q;
	logic [CFG_W-1:0]   entries_q;
	logic [CNT_W-1:0]   limit;
	logic [CODE_W-1:0]  code_q;
	logic [LEN_W-1:0]   len_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [BCNT_W-1:0]  bits_left_q;
	logic [CNT_W-1:0]   addr_q;
	logic               hit_q;
	logic [SYM_W-1:0]   hit_sym_q;
	logic               hold_v_q;
	logic [SYM_W-1:0]   hold_sym_q;
	logic               hold_err_q;
	logic               out_v_q;
	result_t            out_q;
	logic               rd_en;
	logic               can_push;
	logic               push;
	result_t            push_data;
	logic               new_res;
	logic               accept;
	tbl_wr_t            wr;
	lookup_t            req;
	lookup_rsp_t        rsp;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_we) begin
			entries_q <= cfg_wdata;
		end
	end

	// search limit, clamped at the table size
	always_comb begin
		if ({1'b0, entries_q} >= 9'(TABLE_ENTRIES)) begin
			limit = CNT_W'(TABLE_ENTRIES);
		end else begin
			limit = CNT_W'(entries_q);
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// table write on load words
	always_comb begin
		wr.en           = accept && (in_ch.mode == MODE_LOAD)
		               && (9'(in_ch.entry_index) < 9'(TABLE_ENTRIES));
		wr.addr         = ADDR_W'(in_ch.entry_index);
		wr.entry.symbol = in_ch.entry_symbol;
		wr.entry.code   = in_ch.entry_code;
		wr.entry.length = in_ch.entry_length;
	end

	// scan read requests
	assign rd_en = (state_q == ST_SCAN) && (addr_q < limit) && !rsp.match;

	always_comb begin
		req.en     = rd_en;
		req.addr   = addr_q[ADDR_W-1:0];
		req.code   = code_q;
		req.length = len_q;
	end

	hufftbd_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.req    (req),
		.rsp    (rsp)
	);

	// result push into the output register
	assign can_push = !out_v_q || out_ch.ready;
	assign new_res  = hit_q || (len_q == LEN_W'(MAX_CODE_LEN));

	always_comb begin
		push             = 1'b0;
		push_data.symbol = hold_sym_q;
		push_data.error  = hold_err_q;
		push_data.last   = 1'b0;
		if (state_q == ST_DECIDE) begin
			push = new_res && hold_v_q && can_push;
		end else if (state_q == ST_FLUSH) begin
			push           = hold_v_q && can_push;
			push_data.last = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			code_q      <= '0;
			len_q       <= '0;
			bits_left_q <= '0;
			addr_q      <= '0;
			hit_q       <= 1'b0;
			hold_v_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_ch.mode == MODE_DECODE)) begin
						if (in_ch.valid_bits > VBITS_W'(BYTE_W)) begin
							bits_left_q <= BCNT_W'(BYTE_W);
						end else begin
							bits_left_q <= BCNT_W'(in_ch.valid_bits);
						end
						if (in_ch.valid_bits != '0) begin
							state_q <= ST_BIT;
						end
					end
				end
				ST_BIT: begin
					code_q      <= ((code_q << 1) | CODE_W'(byte_q[BYTE_W-1]))
					             & len_mask(LEN_W'(MAX_CODE_LEN));
					len_q       <= len_q + 1'b1;
					bits_left_q <= bits_left_q - 1'b1;
					addr_q      <= '0;
					hit_q       <= 1'b0;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_en) begin
						addr_q <= addr_q + 1'b1;
					end
					if (rsp.match) begin
						hit_q   <= 1'b1;
						state_q <= ST_DECIDE;
					end else if (!rd_en && !rsp.valid) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!(new_res && hold_v_q && !can_push)) begin
						if (new_res) begin
							hold_v_q <= 1'b1;
							code_q   <= '0;
							len_q    <= '0;
						end
						if (bits_left_q == '0) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_BIT;
						end
					end
				end
				ST_FLUSH: begin
					if (!hold_v_q) begin
						state_q <= ST_IDLE;
					end else if (can_push) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_ch.data_byte;
		end else if (state_q == ST_BIT) begin
			byte_q <= byte_q << 1;
		end
		if ((state_q == ST_SCAN) && rsp.match) begin
			hit_sym_q <= rsp.symbol;
		end
		if ((state_q == ST_DECIDE) && new_res && !(hold_v_q && !can_push)) begin
			hold_sym_q <= hit_q ? hit_sym_q : '0;
			hold_err_q <= !hit_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_data;
		end
	end

	assign out_ch.valid  = out_v_q;
	assign out_ch.symbol = out_q.symbol;
	assign out_ch.error  = out_q.error;
	assign out_ch.last   = out_q.last;

	// no held result is left behind once the block is idle
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_v_q)
		else $error("held result left over in idle");

	// running code never grows past the maximum length
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_CODE_LEN))
		else $error("running code too long");

	// a push never overwrites an undelivered word
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_v_q || out_ch.ready))
		else $error("output word overwritten");

	// scan address stays within the search limit
	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (addr_q <= limit))
		else $error("scan address beyond limit");

endmodule

>>> rtl/hufftbd_table.sv
module hufftbd_table
	import hufftbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tbl_wr_t     wr,
	input  lookup_t     req,
	output lookup_rsp_t rsp
);

	entry_t            mem [TABLE_ENTRIES];
	entry_t            rd_q;
	logic              rd_v_q;
	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  len_q;
	logic [CODE_W-1:0] masked;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
	end

	// registered read, key travels with it
	always_ff @(posedge clk) begin
		if (req.en) begin
			rd_q   <= mem[req.addr];
			code_q <= req.code;
			len_q  <= req.length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= req.en;
		end
	end

	// shared compare unit: length and masked code bits
	always_comb begin
		masked     = CODE_W'(rd_q.code) & len_mask(len_q);
		rsp.valid  = rd_v_q;
		rsp.match  = rd_v_q
		          && (LCMP_W'(rd_q.length) == LCMP_W'(len_q))
		          && (masked == code_q);
		rsp.symbol = rd_q.symbol;
	end

endmodule
